[src/wwgs_pkg.sv]
//------------------------------------------------------------------------------
// wwgs_pkg: shared types and codes of the WireWorld grid engine
// Cell codes, item functions, register indexes, channel payloads and the
// controller states.
//------------------------------------------------------------------------------
package wwgs_pkg;

	typedef enum logic [1:0] {
		CELL_EMPTY = 2'd0,
		CELL_WIRE  = 2'd1,
		CELL_HEAD  = 2'd2,
		CELL_TAIL  = 2'd3
	} cell_t;

	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_STEP  = 2'd2
	} func_t;

	localparam logic [0:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [0:0] REG_GRID_HEIGHT = 1'b1;

	localparam logic [7:0] GRID_DIM_RESET = 8'd128;

	typedef struct packed {
		logic [1:0] func;
		logic [6:0] cell_x;
		logic [6:0] cell_y;
		logic [1:0] new_state;
	} req_t;

	typedef struct packed {
		logic [1:0] cell_value;
		logic       step_done;
	} rsp_t;

	typedef struct packed {
		logic [0:0] index;
		logic [7:0] value;
	} cfg_t;

	typedef struct packed {
		logic [7:0] heads;
		cell_t      center;
	} window_t;

	typedef struct packed {
		logic active;
		logic interior;
	} pos_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDWAIT,
		ST_SCAN,
		ST_DRAIN,
		ST_RESP
	} state_t;

endpackage

[src/wwgs_stream_if.sv]
//------------------------------------------------------------------------------
// wwgs_stream_if: valid/ready channel
// One beat moves when valid and ready are both high at a rising clock edge.
//------------------------------------------------------------------------------
interface wwgs_stream_if #(
	parameter type T = logic [0:0]
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/wwgs_ram.sv]
//------------------------------------------------------------------------------
// wwgs_ram: one grid bank
// Single write port and single read port, read data registered.
//------------------------------------------------------------------------------
module wwgs_ram #(
	parameter int DEPTH = 16384,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  wwgs_pkg::cell_t       wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output wwgs_pkg::cell_t       rdata
);

	wwgs_pkg::cell_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/wwgs_rule.sv]
//------------------------------------------------------------------------------
// wwgs_rule: WireWorld transition of one cell
// Counts the head neighbors of a 3x3 window and gives the next cell state.
//------------------------------------------------------------------------------
module wwgs_rule (
	input  wwgs_pkg::window_t win,
	input  wwgs_pkg::pos_t    pos,
	output wwgs_pkg::cell_t   nxt
);

	logic [3:0] head_cnt;
	logic       fire;

	assign head_cnt = 4'($countones(win.heads));
	assign fire     = (head_cnt == 4'd1) || (head_cnt == 4'd2);

	always_comb begin
		nxt = win.center;
		if (pos.active) begin
			case (win.center)
				wwgs_pkg::CELL_WIRE: begin
					nxt = (pos.interior && fire) ? wwgs_pkg::CELL_HEAD : wwgs_pkg::CELL_WIRE;
				end
				wwgs_pkg::CELL_HEAD: nxt = wwgs_pkg::CELL_TAIL;
				wwgs_pkg::CELL_TAIL: nxt = wwgs_pkg::CELL_WIRE;
				default:             nxt = wwgs_pkg::CELL_EMPTY;
			endcase
		end
	end

endmodule

[src/wireworld_grid_step_top.sv]
//------------------------------------------------------------------------------
// wireworld_grid_step_top: WireWorld grid engine
// Holds the grid in two banks and serves cell writes, cell reads and
// whole-grid generation steps.
//------------------------------------------------------------------------------
// Channels: req carries one item per beat (func, cell_x, cell_y, new_state),
// rsp returns exactly one result beat per item (cell_value, step_done), and
// cfg writes grid_width (index 0) or grid_height (index 1) at any time it is
// valid; cfg is always ready.
// A write passes through ST_RESP to the output register, a read through ST_RDWAIT and then ST_RESP.
// A step scans every column of every row of the full bank, reading three
// cells per column through the single read port of the current bank. New
// values go to the other bank, which becomes current when the scan ends.
// After reset both banks are cleared one cell per cycle; req is not ready
// meanwhile.
// A result waits in the output register while the receiver stalls; the next
// item is taken in the meantime and its result is held until rsp frees.
//------------------------------------------------------------------------------
module wireworld_grid_step_top #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	wwgs_stream_if.sink   req,
	wwgs_stream_if.source rsp,
	wwgs_stream_if.sink   cfg
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(MAX_WIDTH + 1);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int DWX   = ($clog2(MAX_WIDTH + 1) > 8) ? $clog2(MAX_WIDTH + 1) : 8;
	localparam int DWY   = ($clog2(MAX_HEIGHT + 1) > 8) ? $clog2(MAX_HEIGHT + 1) : 8;

	wwgs_pkg::state_t state_q, state_d;

	logic [7:0]     grid_width_q, grid_height_q;
	logic [DWX-1:0] w_act;
	logic [DWY-1:0] h_act;

	logic          in_ready, accept, in_area, in_area_q;
	logic [AW-1:0] req_addr;
	logic [AW-1:0] clr_cnt_q;
	logic          bank_q;

	logic          we0, we1, re;
	logic [AW-1:0] waddr, raddr;
	wwgs_pkg::cell_t wdata, rd0, rd1, rd_cur;

	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q;
	logic [1:0]    k_q;
	logic [YW-1:0] scan_row;
	logic          scan_ok;
	logic [AW-1:0] scan_addr;

	logic          scan_vld_s1, rmask_s1;
	logic [1:0]    k_s1;
	logic [XW-1:0] col_s1;
	logic [YW-1:0] row_s1;

	logic            top_acc_q;
	wwgs_pkg::cell_t mid_acc_q;
	logic [2:0]      wt_q, wb_q;
	wwgs_pkg::cell_t wm_q [3];

	logic          wr_vld_s2;
	logic [XW-1:0] col_s2;
	logic [YW-1:0] row_s2;
	logic [AW-1:0] wr_addr_s2;

	wwgs_pkg::window_t win;
	wwgs_pkg::pos_t    pos;
	wwgs_pkg::cell_t   rule_nxt;

	logic [1:0]     res_value_q;
	logic           res_done_q;
	logic           out_valid_q;
	wwgs_pkg::rsp_t out_data_q;

	assign w_act = (DWX'(grid_width_q) > DWX'(MAX_WIDTH)) ? DWX'(MAX_WIDTH) : DWX'(grid_width_q);
	assign h_act = (DWY'(grid_height_q) > DWY'(MAX_HEIGHT)) ? DWY'(MAX_HEIGHT)
		: DWY'(grid_height_q);

	assign in_area  = (DWX'(req.data.cell_x) < w_act) && (DWY'(req.data.cell_y) < h_act);
	assign req_addr = AW'(AW'(req.data.cell_y) * AW'(MAX_WIDTH) + AW'(req.data.cell_x));
	assign accept   = req.valid && in_ready;
	assign req.ready = in_ready;
	assign cfg.ready = 1'b1;
	assign rd_cur   = bank_q ? rd1 : rd0;

	always_comb begin
		scan_row = row_q;
		scan_ok  = 1'b0;
		case (k_q)
			2'd0: begin
				scan_row = row_q - YW'(1);
				scan_ok  = (row_q != '0);
			end
			2'd1: begin
				scan_row = row_q;
				scan_ok  = 1'b1;
			end
			2'd2: begin
				scan_row = row_q + YW'(1);
				scan_ok  = (row_q != YW'(MAX_HEIGHT - 1));
			end
			default: scan_ok = 1'b0;
		endcase
		scan_ok = scan_ok && (col_q != XW'(MAX_WIDTH));
	end

	assign scan_addr = scan_ok ? AW'(AW'(scan_row) * AW'(MAX_WIDTH) + AW'(col_q)) : '0;

	assign win.heads = {wt_q, wm_q[0] == wwgs_pkg::CELL_HEAD, wm_q[2] == wwgs_pkg::CELL_HEAD, wb_q};
	assign win.center = wm_q[1];
	assign pos.active = (DWX'(col_s2) < w_act) && (DWY'(row_s2) < h_act);
	assign pos.interior = (col_s2 != '0) && ((DWX'(col_s2) + DWX'(1)) != w_act)
		&& (row_s2 != '0) && ((DWY'(row_s2) + DWY'(1)) != h_act);
	assign wr_addr_s2 = AW'(AW'(row_s2) * AW'(MAX_WIDTH) + AW'(col_s2));

	wwgs_rule u_rule (
		.win (win),
		.pos (pos),
		.nxt (rule_nxt)
	);

	wwgs_ram #(.DEPTH(DEPTH)) u_bank0 (
		.clk   (clk),
		.we    (we0),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rd0)
	);

	wwgs_ram #(.DEPTH(DEPTH)) u_bank1 (
		.clk   (clk),
		.we    (we1),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rd1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wwgs_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		we0      = 1'b0;
		we1      = 1'b0;
		waddr    = '0;
		wdata    = wwgs_pkg::CELL_EMPTY;
		re       = 1'b0;
		raddr    = '0;
		case (state_q)
			wwgs_pkg::ST_CLEAR: begin
				we0   = 1'b1;
				we1   = 1'b1;
				waddr = clr_cnt_q;
				if (clr_cnt_q == AW'(DEPTH - 1)) begin
					state_d = wwgs_pkg::ST_IDLE;
				end
			end
			wwgs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (req.valid) begin
					case (req.data.func)
						wwgs_pkg::FUNC_WRITE: begin
							if (in_area) begin
								we0   = 1'b1;
								we1   = 1'b1;
								waddr = req_addr;
								wdata = wwgs_pkg::cell_t'(req.data.new_state);
							end
							state_d = wwgs_pkg::ST_RESP;
						end
						wwgs_pkg::FUNC_READ: begin
							re      = in_area;
							raddr   = req_addr;
							state_d = wwgs_pkg::ST_RDWAIT;
						end
						wwgs_pkg::FUNC_STEP: state_d = wwgs_pkg::ST_SCAN;
						default:             state_d = wwgs_pkg::ST_RESP;
					endcase
				end
			end
			wwgs_pkg::ST_RDWAIT: state_d = wwgs_pkg::ST_RESP;
			wwgs_pkg::ST_SCAN: begin
				re    = 1'b1;
				raddr = scan_addr;
				if (k_q == 2'd2 && col_q == XW'(MAX_WIDTH) && row_q == YW'(MAX_HEIGHT - 1)) begin
					state_d = wwgs_pkg::ST_DRAIN;
				end
			end
			wwgs_pkg::ST_DRAIN: begin
				if (!scan_vld_s1 && !wr_vld_s2) begin
					state_d = wwgs_pkg::ST_RESP;
				end
			end
			wwgs_pkg::ST_RESP: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = wwgs_pkg::ST_IDLE;
				end
			end
			default: state_d = wwgs_pkg::ST_IDLE;
		endcase
		if (wr_vld_s2) begin
			waddr = wr_addr_s2;
			wdata = rule_nxt;
			if (bank_q) begin
				we0 = 1'b1;
			end else begin
				we1 = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= wwgs_pkg::GRID_DIM_RESET;
			grid_height_q <= wwgs_pkg::GRID_DIM_RESET;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				wwgs_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg.data.value;
				wwgs_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg.data.value;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			bank_q      <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			k_q         <= '0;
			scan_vld_s1 <= 1'b0;
			wr_vld_s2   <= 1'b0;
		end else begin
			if (state_q == wwgs_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (accept && req.data.func == wwgs_pkg::FUNC_STEP) begin
				col_q <= '0;
				row_q <= '0;
				k_q   <= '0;
			end else if (state_q == wwgs_pkg::ST_SCAN) begin
				if (k_q == 2'd2) begin
					k_q <= '0;
					if (col_q == XW'(MAX_WIDTH)) begin
						col_q <= '0;
						row_q <= row_q + YW'(1);
					end else begin
						col_q <= col_q + XW'(1);
					end
				end else begin
					k_q <= k_q + 2'd1;
				end
			end
			scan_vld_s1 <= (state_q == wwgs_pkg::ST_SCAN);
			wr_vld_s2   <= scan_vld_s1 && (k_s1 == 2'd2) && (col_s1 != '0);
			if (state_q == wwgs_pkg::ST_DRAIN && !scan_vld_s1 && !wr_vld_s2) begin
				bank_q <= ~bank_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		k_s1     <= k_q;
		col_s1   <= col_q;
		row_s1   <= row_q;
		rmask_s1 <= scan_ok;
		col_s2   <= col_s1 - XW'(1);
		row_s2   <= row_s1;
		if (scan_vld_s1) begin
			case (k_s1)
				2'd0: top_acc_q <= rmask_s1 && (rd_cur == wwgs_pkg::CELL_HEAD);
				2'd1: mid_acc_q <= rmask_s1 ? rd_cur : wwgs_pkg::CELL_EMPTY;
				2'd2: begin
					wt_q    <= {top_acc_q, wt_q[2:1]};
					wb_q    <= {rmask_s1 && (rd_cur == wwgs_pkg::CELL_HEAD), wb_q[2:1]};
					wm_q[0] <= wm_q[1];
					wm_q[1] <= wm_q[2];
					wm_q[2] <= mid_acc_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			wwgs_pkg::ST_IDLE: begin
				if (accept) begin
					in_area_q   <= in_area;
					res_done_q  <= 1'b0;
					res_value_q <= (req.data.func == wwgs_pkg::FUNC_WRITE && in_area)
						? req.data.new_state : 2'd0;
				end
			end
			wwgs_pkg::ST_RDWAIT: begin
				res_value_q <= in_area_q ? rd_cur : wwgs_pkg::CELL_EMPTY;
				res_done_q  <= 1'b0;
			end
			wwgs_pkg::ST_DRAIN: begin
				res_value_q <= 2'd0;
				res_done_q  <= 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == wwgs_pkg::ST_RESP && (!out_valid_q || rsp.ready)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == wwgs_pkg::ST_RESP && (!out_valid_q || rsp.ready)) begin
			out_data_q.cell_value <= res_value_q;
			out_data_q.step_done  <= res_done_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_vld_s1 |-> (state_q == wwgs_pkg::ST_SCAN || state_q == wwgs_pkg::ST_DRAIN))
		else $error("scan pipeline active outside a step");

	a_bank_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wwgs_pkg::ST_SCAN) |=> $stable(bank_q))
		else $error("current bank changed during a scan");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> (out_valid_q && $stable(out_data_q)))
		else $error("stalled result was lost or changed");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wwgs_pkg::ST_SCAN) |-> (col_q <= XW'(MAX_WIDTH) && k_q != 2'd3))
		else $error("scan counters out of range");

endmodule
